@@ src/mcrs_pkg.sv @@
// ----------------------------------------------------------------------------
// mcrs_pkg
// Shared constants, request codes and state types of the ring store unit.
// ----------------------------------------------------------------------------
package mcrs_pkg;

   localparam int MAX_CHAINS  = 16;
   localparam int MAX_SLOTS   = 64;
   localparam int DATA_WIDTH  = 32;

   localparam int CHAIN_W     = $clog2(MAX_CHAINS);      // chain index bits
   localparam int SLOT_W      = $clog2(MAX_SLOTS);       // slot pointer bits
   localparam int LEN_W       = 7;                       // chain_length register
   localparam int CNT_W       = 5;                       // chain_count register
   localparam int STORE_DEPTH = MAX_CHAINS * MAX_SLOTS;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_DATA_W  = 48;                      // 42 field bits padded
   localparam int RSP_DATA_W  = 48;                      // 42 field bits padded
   localparam int STATUS_W    = 2;

   localparam logic [LEN_W-1:0] RESET_CHAIN_LENGTH = LEN_W'(20);
   localparam logic [CNT_W-1:0] RESET_CHAIN_COUNT  = CNT_W'(1);

   // Request kinds; codes 6 and 7 are unused.
   typedef enum logic [2:0] {
      REQ_ADD       = 3'd0,
      REQ_REMOVE    = 3'd1,
      REQ_CLEAR     = 3'd2,
      REQ_UPDATE    = 3'd3,
      REQ_READ      = 3'd4,
      REQ_CLEAR_ALL = 3'd5
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_CHAIN = 2'd1,
      STAT_EMPTY     = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHAIN_LENGTH = 2'd0,
      CSR_CHAIN_COUNT  = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MOD,
      ST_DONE
   } state_type;

endpackage

@@ src/multi_chain_ring_store_unit.sv @@
// ----------------------------------------------------------------------------
// multi_chain_ring_store_unit
// Several circular chains sharing one entry store, with per-chain pointers.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  req_     in         tvalid / tready    tuser: req_type; tdata: chain fields
//  rsp_     out        tvalid / tready    tdata: status, data, count, flag
//  csr_     in         valid / ready      index, data (register write)
//
//  Add, remove, clear, clear-all and bad-chain requests pass through ST_EXEC
//  and ST_DONE to the output register; update and read on a non-empty chain
//  also wait in ST_MOD for the seven-step modulo of (head + offset) by the
//  chain length before the store access. All 1024 entries are zeroed after
//  reset, one entry a cycle, and no request is accepted meanwhile. A result
//  in the output register does not stop the next request; a finished one waits.
// ----------------------------------------------------------------------------
module multi_chain_ring_store_unit (
   input  logic                               clock,
   input  logic                               reset,
   // tuser: req_type[2:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [2:0]                         req_tuser,
   // tdata: chain_index[3:0], element_offset[9:4], entry_data[41:10]
   input  logic [mcrs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tdata: status[1:0], read_data[33:2], element_count[40:34],
   //        overwrote_oldest[41]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mcrs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mcrs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mcrs_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mcrs_pkg::*;

   localparam int PROD_W = CHAIN_W + LEN_W;

   // Control and configuration
   state_type                 state_ff, state_in;
   logic [STORE_AW-1:0]       clr_ff, clr_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   // Per-chain pointers
   logic [SLOT_W-1:0]         head_ff [MAX_CHAINS];
   logic [SLOT_W-1:0]         head_in [MAX_CHAINS];
   logic [SLOT_W-1:0]         tail_ff [MAX_CHAINS];
   logic [SLOT_W-1:0]         tail_in [MAX_CHAINS];
   logic [MAX_CHAINS-1:0]     empty_ff, empty_in;

   // Request held during execution
   logic [2:0]                kind_ff, kind_in;
   logic [CHAIN_W-1:0]        chain_ff, chain_in;
   logic [SLOT_W-1:0]         offset_ff, offset_in;
   logic [DATA_WIDTH-1:0]     data_ff, data_in;
   status_type                res_status_ff, res_status_in;
   logic                      res_ovw_ff, res_ovw_in;
   logic                      res_read_ff, res_read_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       out_status_ff, out_status_in;
   logic [DATA_WIDTH-1:0]     out_rdata_ff, out_rdata_in;
   logic [LEN_W-1:0]          out_count_ff, out_count_in;
   logic                      out_ovw_ff, out_ovw_in;

   // Store
   logic [DATA_WIDTH-1:0]     store_mem [STORE_DEPTH];
   logic [DATA_WIDTH-1:0]     mem_rd_ff;
   logic                      mem_we, mem_re;
   logic [STORE_AW-1:0]       mem_addr;
   logic [DATA_WIDTH-1:0]     mem_wdata;

   // Working values
   logic [LEN_W-1:0]          eff_len;
   logic [CNT_W-1:0]          eff_cnt;
   logic [SLOT_W-1:0]         cur_head, cur_tail, head_back, tail_back, new_head;
   logic                      cur_empty, bad_chain;
   logic [PROD_W-1:0]         base;
   logic [LEN_W:0]            held_wrap;
   logic [LEN_W-1:0]          held;
   logic                      req_fire;
   logic                      mod_start;
   logic                      mod_done;
   logic [LEN_W-1:0]          mod_dividend;
   logic [SLOT_W-1:0]         mod_rem;

   mcrs_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (eff_len),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, out_ovw_ff, out_count_ff, out_rdata_ff, out_status_ff};

   always_comb begin
      // Saturated configuration
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_SLOTS)) begin
         eff_len = LEN_W'(MAX_SLOTS);
      end else begin
         eff_len = len_ff;
      end
      if (cnt_ff > CNT_W'(MAX_CHAINS)) begin
         eff_cnt = CNT_W'(MAX_CHAINS);
      end else begin
         eff_cnt = cnt_ff;
      end

      cur_head  = head_ff[chain_ff];
      cur_tail  = tail_ff[chain_ff];
      cur_empty = empty_ff[chain_ff];
      bad_chain = (CNT_W'(chain_ff) >= eff_cnt);
      head_back = (cur_head == '0) ? SLOT_W'(eff_len - LEN_W'(1)) : cur_head - SLOT_W'(1);
      tail_back = (cur_tail == '0) ? SLOT_W'(eff_len - LEN_W'(1)) : cur_tail - SLOT_W'(1);
      base      = PROD_W'(chain_ff) * PROD_W'(eff_len);
      mod_dividend = LEN_W'(cur_head) + LEN_W'(offset_ff);

      // Entries held by the addressed chain, from the current pointers.
      if (cur_tail < cur_head) begin
         held_wrap = (LEN_W+1)'(cur_tail) + (LEN_W+1)'(eff_len) + (LEN_W+1)'(1)
                     - (LEN_W+1)'(cur_head);
      end else begin
         held_wrap = (LEN_W+1)'(cur_tail) - (LEN_W+1)'(cur_head) + (LEN_W+1)'(1);
      end
      held = cur_empty ? '0 : held_wrap[LEN_W-1:0];

      state_in      = state_ff;
      clr_in        = clr_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      kind_in       = kind_ff;
      chain_in      = chain_ff;
      offset_in     = offset_ff;
      data_in       = data_ff;
      res_status_in = res_status_ff;
      res_ovw_in    = res_ovw_ff;
      res_read_in   = res_read_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_status_in = out_status_ff;
      out_rdata_in  = out_rdata_ff;
      out_count_in  = out_count_ff;
      out_ovw_in    = out_ovw_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = STORE_AW'(base) + STORE_AW'(mod_rem);
      mem_wdata     = data_ff;
      mod_start     = 1'b0;
      new_head      = head_back;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + STORE_AW'(1);
            if (clr_ff == {STORE_AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               kind_in   = req_tuser;
               chain_in  = req_tdata[CHAIN_W-1:0];
               offset_in = req_tdata[CHAIN_W +: SLOT_W];
               data_in   = req_tdata[CHAIN_W+SLOT_W +: DATA_WIDTH];
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_status_in = STAT_OK;
            res_ovw_in    = 1'b0;
            res_read_in   = 1'b0;
            state_in      = ST_DONE;
            if (kind_ff == REQ_CLEAR_ALL) begin
               for (int i = 0; i < MAX_CHAINS; i++) begin
                  head_in[i] = '0;
                  tail_in[i] = '0;
               end
               empty_in = '1;
            end else if (bad_chain) begin
               res_status_in = STAT_BAD_CHAIN;
            end else begin
               unique case (kind_ff)
                  REQ_ADD: begin
                     if (cur_empty) begin
                        new_head           = SLOT_W'(eff_len - LEN_W'(1));
                        tail_in[chain_ff]  = new_head;
                        empty_in[chain_ff] = 1'b0;
                     end else if (head_back == cur_tail) begin
                        // Full ring: the oldest entry is overwritten.
                        tail_in[chain_ff] = tail_back;
                        res_ovw_in        = 1'b1;
                     end
                     head_in[chain_ff] = new_head;
                     mem_we   = 1'b1;
                     mem_addr = STORE_AW'(base) + STORE_AW'(new_head);
                  end
                  REQ_REMOVE: begin
                     if (!cur_empty) begin
                        if (cur_tail == cur_head) begin
                           head_in[chain_ff]  = '0;
                           tail_in[chain_ff]  = '0;
                           empty_in[chain_ff] = 1'b1;
                        end else begin
                           tail_in[chain_ff] = tail_back;
                        end
                     end
                  end
                  REQ_CLEAR: begin
                     head_in[chain_ff]  = '0;
                     tail_in[chain_ff]  = '0;
                     empty_in[chain_ff] = 1'b1;
                  end
                  REQ_UPDATE, REQ_READ: begin
                     if (cur_empty) begin
                        res_status_in = STAT_EMPTY;
                     end else begin
                        mod_start = 1'b1;
                        state_in  = ST_MOD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               if (kind_ff == REQ_UPDATE) begin
                  mem_we = 1'b1;
               end else begin
                  mem_re      = 1'b1;
                  res_read_in = 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_ovw_in    = res_ovw_ff;
               out_rdata_in  = res_read_ff ? mem_rd_ff : '0;
               if (kind_ff == REQ_CLEAR_ALL || res_status_ff == STAT_BAD_CHAIN) begin
                  out_count_in = '0;
               end else begin
                  out_count_in = held;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write empties every chain; the store keeps its data.
      if (csr_valid && csr_ready &&
          (csr_index == CSR_CHAIN_LENGTH || csr_index == CSR_CHAIN_COUNT)) begin
         if (csr_index == CSR_CHAIN_LENGTH) begin
            len_in = csr_data[LEN_W-1:0];
         end else begin
            cnt_in = csr_data[CNT_W-1:0];
         end
         for (int i = 0; i < MAX_CHAINS; i++) begin
            head_in[i] = '0;
            tail_in[i] = '0;
         end
         empty_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         len_ff       <= RESET_CHAIN_LENGTH;
         cnt_ff       <= RESET_CHAIN_COUNT;
         empty_ff     <= '1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CHAINS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      chain_ff      <= chain_in;
      offset_ff     <= offset_in;
      data_ff       <= data_in;
      res_status_ff <= res_status_in;
      res_ovw_ff    <= res_ovw_in;
      res_read_ff   <= res_read_in;
      out_status_ff <= out_status_in;
      out_rdata_ff  <= out_rdata_in;
      out_count_ff  <= out_count_in;
      out_ovw_ff    <= out_ovw_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= store_mem[mem_addr];
      end
   end

endmodule

@@ src/mcrs_mod_unit.sv @@
// ----------------------------------------------------------------------------
// mcrs_mod_unit
// Restoring modulo of a 7-bit sum by the chain length, one bit per cycle.
// ----------------------------------------------------------------------------
module mcrs_mod_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mcrs_pkg::LEN_W-1:0]   dividend,
   input  logic [mcrs_pkg::LEN_W-1:0]   divisor,
   output logic                         done,
   output logic [mcrs_pkg::SLOT_W-1:0]  remainder
);
   import mcrs_pkg::*;

   localparam int STEPS  = LEN_W;
   localparam int STEP_W = $clog2(STEPS);
   localparam int WIDE_W = LEN_W + STEPS - 1;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [LEN_W-1:0]    rem_ff, rem_in;
   logic [LEN_W-1:0]    div_ff, div_in;
   logic [WIDE_W-1:0]   shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      shifted = WIDE_W'(div_ff) << step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(STEPS - 1);
         rem_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         // Subtract divisor * 2^step whenever it still fits.
         if (WIDE_W'(rem_ff) >= shifted) begin
            rem_in = rem_ff - shifted[LEN_W-1:0];
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[SLOT_W-1:0];

endmodule

@@ tb/multi_chain_ring_store_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_chain_ring_store_unit_tb
// Self-checking bench for the ring store unit. A scoreboard class keeps its own
// copy of the chain pointers, the entry store and both size registers, and
// works out the expected result of every accepted request. Responses are
// checked field by field in order. The stimulus starts with directed corner
// cases, then runs random request streams under a range of register settings.
// The sender and the receiver both throttle at random, and the receiver also
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module multi_chain_ring_store_unit_tb;
   import mcrs_pkg::*;

   // Request codes the block treats as no-ops.
   localparam logic [2:0] REQ_SPARE_A = 3'd6;
   localparam logic [2:0] REQ_SPARE_B = 3'd7;

   localparam int PHASES    = 10;
   localparam int LONG_HOLD = 400;
   localparam int MAX_NOTES = 30;

   // Register values per random phase; some are out of range on purpose.
   localparam int PHASE_LEN   [PHASES] = '{2, 64, 5, 127, 0, 20, 130, 64, 1, 9};
   localparam int PHASE_CNT   [PHASES] = '{4, 1, 16, 31, 3, 0, 227, 16, 2, 5};
   localparam int PHASE_ITEMS [PHASES] = '{90, 160, 110, 110, 60, 30, 80, 100, 60, 100};
   localparam int PHASE_ADDS  [PHASES] = '{40, 80, 40, 45, 40, 40, 40, 50, 50, 40};
   localparam bit PHASE_CLRS  [PHASES] = '{1, 0, 1, 1, 1, 1, 1, 1, 1, 1};

   typedef struct {
      logic [1:0]  status;
      logic [31:0] read_data;
      logic [6:0]  count;
      logic        overwrote;
   } ring_result_type;

   class ring_scoreboard;
      logic [LEN_W-1:0] length_reg;
      logic [CNT_W-1:0] count_reg;
      int unsigned      head_ptr [MAX_CHAINS];
      int unsigned      tail_ptr [MAX_CHAINS];
      bit               is_empty [MAX_CHAINS];
      logic [31:0]      entries  [STORE_DEPTH];
      ring_result_type  expected_q [$];
      int               mismatches;
      int               checked;
      int               overwrites;
      int               bad_chain_seen;
      int               empty_seen;

      function new();
         length_reg = RESET_CHAIN_LENGTH;
         count_reg  = RESET_CHAIN_COUNT;
         foreach (entries[i]) entries[i] = '0;
         empty_chains();
      endfunction

      function int unsigned ring_len();
         if (length_reg == 0) return 1;
         if (length_reg > MAX_SLOTS) return MAX_SLOTS;
         return length_reg;
      endfunction

      function int unsigned chains_in_use();
         return (count_reg > MAX_CHAINS) ? MAX_CHAINS : count_reg;
      endfunction

      function void empty_chains();
         for (int i = 0; i < MAX_CHAINS; i++) begin
            head_ptr[i] = 0;
            tail_ptr[i] = 0;
            is_empty[i] = 1'b1;
         end
      endfunction

      function int unsigned held(int unsigned c);
         int unsigned len;
         len = ring_len();
         if (is_empty[c]) return 0;
         if (tail_ptr[c] < head_ptr[c]) return tail_ptr[c] + len + 1 - head_ptr[c];
         return tail_ptr[c] - head_ptr[c] + 1;
      endfunction

      function int unsigned step_back(int unsigned p, int unsigned len);
         return (p == 0) ? len - 1 : p - 1;
      endfunction

      // Either size register empties every chain; stored data stays.
      function void write_register(csr_index_type idx, logic [7:0] value);
         if (idx == CSR_CHAIN_LENGTH) length_reg = value[LEN_W-1:0];
         else count_reg = value[CNT_W-1:0];
         empty_chains();
      endfunction

      function void note_request(logic [2:0] kind, logic [3:0] chain,
                                 logic [5:0] offset, logic [31:0] data);
         int unsigned     len;
         int unsigned     c;
         int unsigned     slot;
         ring_result_type r;
         len         = ring_len();
         c           = chain;
         r.status    = STAT_OK;
         r.read_data = '0;
         r.count     = '0;
         r.overwrote = 1'b0;
         if (kind == REQ_CLEAR_ALL) begin
            empty_chains();
         end else if (c >= chains_in_use()) begin
            r.status = STAT_BAD_CHAIN;
         end else begin
            case (kind)
               REQ_ADD: begin
                  if (is_empty[c]) begin
                     head_ptr[c] = len - 1;
                     tail_ptr[c] = len - 1;
                     is_empty[c] = 1'b0;
                  end else begin
                     head_ptr[c] = step_back(head_ptr[c], len);
                     // The head ran into the tail: the oldest entry is lost.
                     if (head_ptr[c] == tail_ptr[c]) begin
                        tail_ptr[c] = step_back(tail_ptr[c], len);
                        r.overwrote = 1'b1;
                     end
                  end
                  entries[c * len + head_ptr[c]] = data;
               end
               REQ_REMOVE: begin
                  if (!is_empty[c]) begin
                     if (tail_ptr[c] == head_ptr[c]) begin
                        head_ptr[c] = 0;
                        tail_ptr[c] = 0;
                        is_empty[c] = 1'b1;
                     end else begin
                        tail_ptr[c] = step_back(tail_ptr[c], len);
                     end
                  end
               end
               REQ_CLEAR: begin
                  head_ptr[c] = 0;
                  tail_ptr[c] = 0;
                  is_empty[c] = 1'b1;
               end
               REQ_UPDATE, REQ_READ: begin
                  if (is_empty[c]) begin
                     r.status = STAT_EMPTY;
                  end else begin
                     slot = c * len + (head_ptr[c] + offset) % len;
                     if (kind == REQ_UPDATE) entries[slot] = data;
                     else r.read_data = entries[slot];
                  end
               end
               default: ;
            endcase
            r.count = 7'(held(c));
         end
         expected_q.insert(expected_q.size(), r);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= MAX_NOTES) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_response(logic [RSP_DATA_W-1:0] tdata);
         ring_result_type e;
         if (expected_q.size() == 0) begin
            report($sformatf("response with nothing expected, tdata %h", tdata));
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (e.overwrote) overwrites++;
         if (e.status == STAT_BAD_CHAIN) bad_chain_seen++;
         if (e.status == STAT_EMPTY) empty_seen++;
         if (tdata[1:0] !== e.status)
            report($sformatf("result %0d status %0d, expected %0d",
                             checked, tdata[1:0], e.status));
         if (tdata[33:2] !== e.read_data)
            report($sformatf("result %0d read_data %h, expected %h",
                             checked, tdata[33:2], e.read_data));
         if (tdata[40:34] !== e.count)
            report($sformatf("result %0d element_count %0d, expected %0d",
                             checked, tdata[40:34], e.count));
         if (tdata[41] !== e.overwrote)
            report($sformatf("result %0d overwrote_oldest %b, expected %b",
                             checked, tdata[41], e.overwrote));
      endtask
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [2:0]              req_tuser  = '0;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_data   = '0;

   ring_scoreboard sb;
   int  burst_left     = 0;
   int  sender_gap_max = 4;
   int  items_sent     = 0;
   int  settings_used  = 1;
   logic hold_toggle   = 1'b0;

   // Receiver-private state.
   logic hold_seen    = 1'b0;
   int   hold_left    = 0;
   int   stall_mode   = 0;
   int   pattern_left = 0;

   multi_chain_ring_store_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: picks a new stall pattern at random times and obeys a
   // long hold-off whenever the stimulus flips hold_toggle.
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = LONG_HOLD;
      end
      if (pattern_left == 0) begin
         stall_mode   = $urandom_range(0, 3);
         pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ((pattern_left % 8) < 5);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   task automatic send_request(input logic [2:0] kind, input logic [3:0] chain,
                               input logic [5:0] offset, input logic [31:0] data);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, sender_gap_max);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, data, offset, chain};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, chain, offset, data);
      burst_left--;
      items_sent++;
   endtask

   task automatic stop_requests();
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic wait_drained();
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // Both size registers, back to back; only called with no request in flight.
   task automatic write_sizes(input logic [7:0] length_val, input logic [7:0] count_val);
      csr_valid <= 1'b1;
      csr_index <= CSR_CHAIN_LENGTH;
      csr_data  <= length_val;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(CSR_CHAIN_LENGTH, length_val);
      csr_index <= CSR_CHAIN_COUNT;
      csr_data  <= count_val;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(CSR_CHAIN_COUNT, count_val);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Mostly valid chains and offsets inside the held entries, with some noise.
   task automatic random_request(input int add_pct, input bit clears);
      int unsigned pick;
      int unsigned chains;
      int unsigned c;
      int unsigned n;
      logic [2:0]  kind;
      logic [5:0]  offset;
      logic [31:0] data;
      pick = $urandom_range(0, 99);
      if (pick < add_pct) begin
         kind = REQ_ADD;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 20) kind = REQ_REMOVE;
         else if (pick < 26) kind = clears ? REQ_CLEAR : REQ_READ;
         else if (pick < 50) kind = REQ_UPDATE;
         else if (pick < 92) kind = REQ_READ;
         else if (pick < 95) kind = clears ? REQ_CLEAR_ALL : REQ_READ;
         else if (pick < 97) kind = REQ_SPARE_A;
         else kind = REQ_SPARE_B;
      end
      chains = sb.chains_in_use();
      if (chains > 0 && $urandom_range(0, 9) != 0) c = $urandom_range(0, chains - 1);
      else c = $urandom_range(0, MAX_CHAINS - 1);
      n = (c < chains) ? sb.held(c) : 0;
      if (n > 0 && $urandom_range(0, 3) != 0) offset = 6'($urandom_range(0, n - 1));
      else offset = 6'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
         0:       data = '0;
         1:       data = '1;
         default: data = $urandom;
      endcase
      send_request(kind, c[3:0], offset, data);
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset sizes: empty, bad-chain and wrap cases.
      send_request(REQ_READ,      4'd0,  6'd0,  32'h1111_1111);
      send_request(REQ_UPDATE,    4'd0,  6'd5,  32'h2222_2222);
      send_request(REQ_REMOVE,    4'd0,  6'd0,  32'h0);
      send_request(REQ_ADD,       4'd1,  6'd0,  32'h3333_3333);
      send_request(REQ_ADD,       4'd15, 6'd0,  32'hFFFF_FFFF);
      send_request(REQ_CLEAR_ALL, 4'd15, 6'd63, 32'hFFFF_FFFF);
      send_request(REQ_ADD,       4'd0,  6'd0,  32'h0000_0000);
      send_request(REQ_ADD,       4'd0,  6'd0,  32'hFFFF_FFFF);
      send_request(REQ_READ,      4'd0,  6'd0,  32'h0);
      send_request(REQ_READ,      4'd0,  6'd1,  32'h0);
      send_request(REQ_READ,      4'd0,  6'd63, 32'h0);
      send_request(REQ_UPDATE,    4'd0,  6'd63, 32'hA5A5_A5A5);
      send_request(REQ_READ,      4'd0,  6'd63, 32'h0);
      send_request(REQ_SPARE_A,   4'd0,  6'd0,  32'h0);
      send_request(REQ_SPARE_B,   4'd15, 6'd63, 32'hFFFF_FFFF);
      send_request(REQ_CLEAR,     4'd0,  6'd0,  32'h0);
      send_request(REQ_REMOVE,    4'd0,  6'd0,  32'h0);
      stop_requests();
      wait_drained();

      // One-slot rings on every chain: the second add overwrites the first.
      write_sizes(8'd1, 8'd16);
      send_request(REQ_ADD,       4'd15, 6'd0,  32'h1234_5678);
      send_request(REQ_ADD,       4'd15, 6'd0,  32'h8765_4321);
      send_request(REQ_READ,      4'd15, 6'd63, 32'h0);
      send_request(REQ_REMOVE,    4'd15, 6'd0,  32'h0);
      send_request(REQ_REMOVE,    4'd15, 6'd0,  32'h0);
      send_request(REQ_UPDATE,    4'd15, 6'd7,  32'h5A5A_5A5A);
      send_request(REQ_ADD,       4'd3,  6'd0,  32'hDEAD_BEEF);
      send_request(REQ_CLEAR_ALL, 4'd3,  6'd0,  32'h0);
      stop_requests();
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         write_sizes(PHASE_LEN[p][7:0], PHASE_CNT[p][7:0]);
         sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
            // Long receiver stall while requests keep coming, so the input backs up.
            if (p == 2 && i == 40) hold_toggle <= ~hold_toggle;
            if (p == 7 && i == 50) begin
               stop_requests();
               wait_drained();
            end
            random_request(PHASE_ADDS[p], PHASE_CLRS[p]);
         end
         stop_requests();
         wait_drained();
      end

      repeat (24) @(posedge clock);
      if (sb.expected_q.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
      $display("Ran %0d requests over %0d register settings; %0d results checked.",
               items_sent, settings_used, sb.checked);
      $display("Seen: %0d overwrites, %0d bad-chain and %0d empty-chain results.",
               sb.overwrites, sb.bad_chain_seen, sb.empty_seen);
      if (sb.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout: the run did not complete.");
      $display("Some tests failed");
      $finish;
   end

endmodule
